FILE: hdl/kppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kppc_pkg
// Shared types and constants of the two-key press classifier.
// ----------------------------------------------------------------------------
package kppc_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int NOW_WIDTH       = 32;
    localparam int INTERVAL_WIDTH  = 16;
    localparam int REP_COUNT_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [INTERVAL_WIDTH-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [INTERVAL_WIDTH-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [INTERVAL_WIDTH-1:0] REPEAT_RST     = 16'd250;
    localparam logic                      COMPANION_RST  = 1'b0;

    // per-key debouncer phase
    typedef enum logic [1:0] {
        PH_OFF    = 2'd0,
        PH_TO_ON  = 2'd1,
        PH_ON     = 2'd2,
        PH_TO_OFF = 2'd3
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT     = 2'd2,
        CFG_COMPANION  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [INTERVAL_WIDTH-1:0] debounce_ms;
        logic [INTERVAL_WIDTH-1:0] long_press_ms;
        logic [INTERVAL_WIDTH-1:0] repeat_ms;
        logic                      companion_enable;
    } cfg_t;

    // events raised by one key for one sample
    typedef struct packed {
        logic is_short;
        logic is_long;
        logic is_repeat;
        logic is_both;   // both-press, also bumps the other key's count
    } key_evt_t;

endpackage

FILE: hdl/kppc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kppc_if
// Valid/ready channels for key samples and classified results.
// ----------------------------------------------------------------------------
interface kppc_sample_if;
    logic        valid;
    logic        ready;
    logic        key_a;
    logic        key_b;
    logic [31:0] now_ms;

    modport source (output valid, key_a, key_b, now_ms, input ready);
    modport sink   (input valid, key_a, key_b, now_ms, output ready);
endinterface

interface kppc_result_if;
    logic        valid;
    logic        ready;
    logic        short_a;
    logic        long_a;
    logic        repeat_a;
    logic [15:0] repeat_count_a;
    logic        short_b;
    logic        long_b;
    logic        repeat_b;
    logic [15:0] repeat_count_b;
    logic        both_press;
    logic        pressed_a;
    logic        pressed_b;

    modport source (output valid, short_a, long_a, repeat_a, repeat_count_a,
                    short_b, long_b, repeat_b, repeat_count_b, both_press,
                    pressed_a, pressed_b, input ready);
    modport sink   (input valid, short_a, long_a, repeat_a, repeat_count_a,
                    short_b, long_b, repeat_b, repeat_count_b, both_press,
                    pressed_a, pressed_b, output ready);
endinterface

FILE: hdl/kppc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kppc_cfg_regs
// Write-only configuration registers with reset defaults.
// ----------------------------------------------------------------------------
module kppc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kppc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [kppc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output kppc_pkg::cfg_t                       cfg
);

    kppc_pkg::cfg_t cfg_reg;
    kppc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (kppc_pkg::cfg_idx_t'(cfg_index))
                kppc_pkg::CFG_DEBOUNCE:   cfg_next.debounce_ms      = cfg_wdata;
                kppc_pkg::CFG_LONG_PRESS: cfg_next.long_press_ms    = cfg_wdata;
                kppc_pkg::CFG_REPEAT:     cfg_next.repeat_ms        = cfg_wdata;
                kppc_pkg::CFG_COMPANION:  cfg_next.companion_enable = cfg_wdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= kppc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms    <= kppc_pkg::LONG_PRESS_RST;
            cfg_reg.repeat_ms        <= kppc_pkg::REPEAT_RST;
            cfg_reg.companion_enable <= kppc_pkg::COMPANION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/kppc_key_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kppc_key_fsm
// Next-state and event logic of one key's debounce/long/repeat machine.
// ----------------------------------------------------------------------------
module kppc_key_fsm #(
    parameter int TIME_WIDTH  = kppc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = kppc_pkg::COUNT_WIDTH_DEF
) (
    input  kppc_pkg::cfg_t         cfg,
    input  logic                   level,
    input  logic [TIME_WIDTH-1:0]  now,
    input  kppc_pkg::phase_t       phase,
    input  logic [TIME_WIDTH-1:0]  deadline,
    input  logic [COUNT_WIDTH-1:0] count,
    input  kppc_pkg::phase_t       other_phase,
    input  logic [COUNT_WIDTH-1:0] other_count,
    output kppc_pkg::phase_t       phase_next,
    output logic [TIME_WIDTH-1:0]  deadline_next,
    output logic [COUNT_WIDTH-1:0] count_next,
    output kppc_pkg::key_evt_t     evt
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   timeout;
    logic                   count_zero;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [TIME_WIDTH-1:0]  dl_debounce;
    logic [TIME_WIDTH-1:0]  dl_long;
    logic [TIME_WIDTH-1:0]  dl_repeat;
    logic                   couple;

    assign timeout     = (now >= deadline);
    assign count_zero  = (count == '0);
    assign count_inc   = (count == COUNT_MAX) ? count : count + 1'b1;
    assign dl_debounce = now + TIME_WIDTH'(cfg.debounce_ms);
    assign dl_long     = now + TIME_WIDTH'(cfg.long_press_ms);
    assign dl_repeat   = now + TIME_WIDTH'(cfg.repeat_ms);
    assign couple      = count_zero && cfg.companion_enable
                         && (other_phase == kppc_pkg::PH_ON) && (other_count == '0);

    // next phase
    always_comb
    begin
        phase_next = phase;
        unique case (phase)
            kppc_pkg::PH_OFF:
            begin
                if (level)
                    phase_next = kppc_pkg::PH_TO_ON;
            end
            kppc_pkg::PH_TO_ON:
            begin
                if (timeout)
                    phase_next = level ? kppc_pkg::PH_ON : kppc_pkg::PH_OFF;
            end
            kppc_pkg::PH_ON:
            begin
                if (!level)
                    phase_next = kppc_pkg::PH_TO_OFF;
            end
            kppc_pkg::PH_TO_OFF:
            begin
                if (timeout)
                    phase_next = level ? kppc_pkg::PH_ON : kppc_pkg::PH_OFF;
            end
            default: phase_next = kppc_pkg::PH_OFF;
        endcase
    end

    // deadline, count and events
    always_comb
    begin
        deadline_next = deadline;
        count_next    = count;
        evt           = '0;
        unique case (phase)
            kppc_pkg::PH_OFF:
            begin
                if (level)
                    deadline_next = dl_debounce;
            end
            kppc_pkg::PH_TO_ON:
            begin
                if (timeout && level)
                    deadline_next = dl_long;
            end
            kppc_pkg::PH_ON:
            begin
                if (!level)
                begin
                    deadline_next = dl_debounce;
                end
                else if (timeout)
                begin
                    deadline_next = dl_repeat;
                    evt.is_long   = count_zero;
                    evt.is_repeat = 1'b1;
                    count_next    = count_inc;
                end
                else if (couple)
                begin
                    evt.is_both = 1'b1;
                    count_next  = count_inc;
                end
            end
            kppc_pkg::PH_TO_OFF:
            begin
                if (timeout && !level)
                begin
                    if (count_zero)
                        evt.is_short = 1'b1;
                    else
                        count_next = '0;
                end
            end
            default: count_next = count;
        endcase
    end

endmodule

FILE: hdl/key_pair_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_pair_press_classifier_core
// Debounce, long-press, auto-repeat and both-press classifier for two keys.
// ----------------------------------------------------------------------------
// usage:
//   - samples channel: one transfer carries both raw key levels and the
//     current millisecond time; key a is classified before key b
//   - events channel: one transfer per sample with the short, long and
//     repeat flags of each key, the repeat counts, both_press and the
//     stable pressed levels
//   - cfg port: one register write per cycle with cfg_we high; writes are
//     expected only while no sample is in flight
//   - path: a taken sample is held in the sample register, classified and
//     stored in the result register, which drives the events channel
//   - throughput: one sample per cycle while the events channel is not
//     stalled; the key state update is a single pass of two chained key
//     machines between the sample register and the result register
//   - stall: while the result register is held, the sample register can
//     still take one more transfer, then samples.ready drops
//   - reset: both keys go to the off phase with zero deadline and count,
//     registers return to 20 / 1000 / 250 / 0
// ----------------------------------------------------------------------------
module key_pair_press_classifier_core #(
    parameter int TIME_WIDTH  = kppc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = kppc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kppc_sample_if.sink                          samples,
    kppc_result_if.source                        events,
    input  logic                                 cfg_we,
    input  logic [kppc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [kppc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    kppc_pkg::cfg_t cfg;

    // sample register
    logic                              smp_vld_reg;
    logic                              smp_key_a_reg;
    logic                              smp_key_b_reg;
    logic [kppc_pkg::NOW_WIDTH-1:0]    smp_now_reg;

    // key state
    kppc_pkg::phase_t                  phase_a_reg, phase_b_reg;
    logic [TIME_WIDTH-1:0]             deadline_a_reg, deadline_b_reg;
    logic [COUNT_WIDTH-1:0]            count_a_reg, count_b_reg;

    // result register
    logic                              res_vld_reg;
    kppc_pkg::key_evt_t                res_evt_a_reg, res_evt_b_reg;
    logic [kppc_pkg::REP_COUNT_WIDTH-1:0] res_cnt_a_reg, res_cnt_b_reg;
    logic                              res_pressed_a_reg, res_pressed_b_reg;

    logic                              advance;
    logic [63:0]                       now_wide;
    logic [TIME_WIDTH-1:0]             now;

    // key a results
    kppc_pkg::phase_t                  phase_a_next;
    logic [TIME_WIDTH-1:0]             deadline_a_next;
    logic [COUNT_WIDTH-1:0]            count_a_mid;
    logic [COUNT_WIDTH-1:0]            count_a_next;
    kppc_pkg::key_evt_t                evt_a;

    // key b results
    logic [COUNT_WIDTH-1:0]            count_b_mid;
    kppc_pkg::phase_t                  phase_b_next;
    logic [TIME_WIDTH-1:0]             deadline_b_next;
    logic [COUNT_WIDTH-1:0]            count_b_next;
    kppc_pkg::key_evt_t                evt_b;

    logic [31:0]                       cnt_a_wide, cnt_b_wide;
    logic [kppc_pkg::REP_COUNT_WIDTH-1:0] rep_cnt_a, rep_cnt_b;

    kppc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // the held sample moves on when the result register is free or drains
    assign advance       = smp_vld_reg && (!res_vld_reg || events.ready);
    assign samples.ready = !smp_vld_reg || advance;

    // time at the configured width, zero-extended or truncated
    assign now_wide = 64'(smp_now_reg);
    assign now      = now_wide[TIME_WIDTH-1:0];

    // key a sees key b as it was before this sample
    kppc_key_fsm #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_a (
        .cfg           (cfg),
        .level         (smp_key_a_reg),
        .now           (now),
        .phase         (phase_a_reg),
        .deadline      (deadline_a_reg),
        .count         (count_a_reg),
        .other_phase   (phase_b_reg),
        .other_count   (count_b_reg),
        .phase_next    (phase_a_next),
        .deadline_next (deadline_a_next),
        .count_next    (count_a_mid),
        .evt           (evt_a)
    );

    // a both-press raised by key a also bumps key b's count
    assign count_b_mid = (evt_a.is_both && (count_b_reg != COUNT_MAX))
                         ? count_b_reg + 1'b1 : count_b_reg;

    // key b sees key a after its update
    kppc_key_fsm #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_b (
        .cfg           (cfg),
        .level         (smp_key_b_reg),
        .now           (now),
        .phase         (phase_b_reg),
        .deadline      (deadline_b_reg),
        .count         (count_b_mid),
        .other_phase   (phase_a_next),
        .other_count   (count_a_mid),
        .phase_next    (phase_b_next),
        .deadline_next (deadline_b_next),
        .count_next    (count_b_next),
        .evt           (evt_b)
    );

    // and a both-press raised by key b bumps key a's count
    assign count_a_next = (evt_b.is_both && (count_a_mid != COUNT_MAX))
                          ? count_a_mid + 1'b1 : count_a_mid;

    // repeat counts are the count before the event, zero without one
    assign cnt_a_wide = 32'(count_a_reg);
    assign cnt_b_wide = 32'(count_b_mid);
    assign rep_cnt_a  = evt_a.is_repeat ? cnt_a_wide[kppc_pkg::REP_COUNT_WIDTH-1:0] : '0;
    assign rep_cnt_b  = evt_b.is_repeat ? cnt_b_wide[kppc_pkg::REP_COUNT_WIDTH-1:0] : '0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg    <= 1'b0;
            res_vld_reg    <= 1'b0;
            phase_a_reg    <= kppc_pkg::PH_OFF;
            phase_b_reg    <= kppc_pkg::PH_OFF;
            deadline_a_reg <= '0;
            deadline_b_reg <= '0;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
        end
        else
        begin
            if (samples.ready)
                smp_vld_reg <= samples.valid;
            if (advance)
                res_vld_reg <= 1'b1;
            else if (events.ready)
                res_vld_reg <= 1'b0;
            if (advance)
            begin
                phase_a_reg    <= phase_a_next;
                phase_b_reg    <= phase_b_next;
                deadline_a_reg <= deadline_a_next;
                deadline_b_reg <= deadline_b_next;
                count_a_reg    <= count_a_next;
                count_b_reg    <= count_b_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            smp_key_a_reg <= samples.key_a;
            smp_key_b_reg <= samples.key_b;
            smp_now_reg   <= samples.now_ms;
        end
        if (advance)
        begin
            res_evt_a_reg     <= evt_a;
            res_evt_b_reg     <= evt_b;
            res_cnt_a_reg     <= rep_cnt_a;
            res_cnt_b_reg     <= rep_cnt_b;
            res_pressed_a_reg <= (phase_a_next == kppc_pkg::PH_ON);
            res_pressed_b_reg <= (phase_b_next == kppc_pkg::PH_ON);
        end
    end

    assign events.valid          = res_vld_reg;
    assign events.short_a        = res_evt_a_reg.is_short;
    assign events.long_a         = res_evt_a_reg.is_long;
    assign events.repeat_a       = res_evt_a_reg.is_repeat;
    assign events.repeat_count_a = res_cnt_a_reg;
    assign events.short_b        = res_evt_b_reg.is_short;
    assign events.long_b         = res_evt_b_reg.is_long;
    assign events.repeat_b       = res_evt_b_reg.is_repeat;
    assign events.repeat_count_b = res_cnt_b_reg;
    assign events.both_press     = res_evt_a_reg.is_both | res_evt_b_reg.is_both;
    assign events.pressed_a      = res_pressed_a_reg;
    assign events.pressed_b      = res_pressed_b_reg;

    // the shown pressed level follows the stored phase
    a_pressed_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> events.pressed_a == (phase_a_reg == kppc_pkg::PH_ON))
        else $error("pressed_a does not match key a phase");

    // a both-press only with coupling on
    a_both_needs_coupling: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (evt_a.is_both || evt_b.is_both) |-> cfg.companion_enable)
        else $error("both-press without coupling");

    // a long press leaves a nonzero event count behind
    a_long_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && evt_a.is_long |=> count_a_reg != '0)
        else $error("key a count zero after long press");

    // key b's phase and count move only with a processed sample
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_b_reg) && $stable(count_b_reg))
        else $error("key b state changed without a sample");

endmodule
